>>> sv/msr_pkg.sv
// Shared types and constants for the mode sense 10-to-6 response remap unit.
package msr_pkg;

  // Header sizes of the two response forms and the result size ceiling
  localparam logic [15:0] HDR10_BYTES  = 16'd8;
  localparam logic [16:0] HDR6_BYTES   = 17'd4;
  localparam logic [16:0] RESULT_LIMIT = 17'd256;
  localparam logic [8:0]  CAP_RESET    = 9'd256;

  // Output queue depth: one header burst
  localparam int unsigned QDEPTH = 4;

  // One result word
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fail;
  } result_t;

  // Words produced by one input word, handed to the output queue
  typedef struct packed {
    logic [2:0]         n;
    result_t [3:0]      w;
  } push_t;

endpackage

>>> sv/msr_obuf.sv
// Four-entry shift queue that holds result words until the sink takes them.
module msr_obuf
  import msr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_en,
  input  push_t      push,
  output logic [2:0] free,
  output logic       out_tvalid,
  input  logic       out_tready,
  output result_t    out_word
);

  result_t [3:0] buf_r, buf_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          pop;
  logic [2:0]    base;
  logic [2:0]    n_eff;

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_word   = buf_r[0];
  assign pop        = out_tvalid && out_tready;
  // slots available this cycle, counting the word leaving now
  assign free       = 3'(QDEPTH) - cnt_r + {2'b0, pop};

  // shift on pop, then append the pushed words behind the survivors
  always_comb begin
    base  = cnt_r - {2'b0, pop};
    n_eff = push_en ? push.n : 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (pop && i < 3) begin
        buf_nxt[i] = buf_r[i+1];
      end else begin
        buf_nxt[i] = buf_r[i];
      end
    end
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < n_eff && base + 3'(k) == 3'(i)) begin
          buf_nxt[i] = push.w[k];
        end
      end
    end
    cnt_nxt = base + n_eff;
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> sv/mode_sense10_to_6_response_remap_unit.sv
// Top level: rewrites a MODE SENSE(10) response byte stream into MODE SENSE(6) form.
//
//  channel | dir | tdata                         | tuser            | tlast
//  in_     | in  | [7:0] data_byte, [23:8] total | starts_response  | -
//  out_    | out | [7:0] out_byte                | failed           | last_byte
//  cfg_    | in  | cfg_wdata[8:0] out_capacity   | -                | -
//
// One input word per cycle while in_tready is high. A word is held in the input register,
// then translated into the four-entry output queue, and its results leave from the queue head.
// Header byte 7 pushes four words at once; the seven header bytes before it push
// nothing and empty the queue, so a ready sink never stalls the input. A stalled
// sink stalls the input once the queue lacks room for the held word's results.
// Reset (rst_n low, synchronous) empties the queue and leaves the unit idle,
// ignoring bytes until a start marker; out_capacity resets to 256.
module mode_sense10_to_6_response_remap_unit
  import msr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] data_byte, [23:8] total_bytes
  input  logic        in_tuser,   // [0] starts_response
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // last_byte
  output logic        out_tuser,  // [0] failed
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);

  // input register
  logic        iv_r;
  logic [7:0]  b_r;
  logic [15:0] tot_r;
  logic        st_r;

  // response state
  logic [8:0]  cap_r;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  med_r, med_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic [7:0]  dhi_r, dhi_nxt;
  logic [15:0] dlen_r, dlen_nxt;
  logic        drop_r, drop_nxt;

  push_t       push;
  logic [2:0]  free;
  logic        proc;
  result_t     out_word;

  logic [15:0] desc;
  logic [15:0] pages;
  logic [16:0] result;
  logic [16:0] result_m1;
  result_t     err_w;

  assign err_w = '{data: 8'd0, last: 1'b1, fail: 1'b1};

  // process the held word when the queue has room for all its results
  assign proc      = iv_r && (push.n <= free);
  assign in_tready = !iv_r || proc;

  // input register load
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      b_r   <= in_tdata[7:0];
      tot_r <= in_tdata[23:8];
      st_r  <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_tready) begin
      iv_r <= in_tvalid;
    end
  end

  // per-byte translation
  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    med_nxt   = med_r;
    dev_nxt   = dev_r;
    dhi_nxt   = dhi_r;
    dlen_nxt  = dlen_r;
    drop_nxt  = drop_r;
    push      = '0;
    desc      = {dhi_r, b_r};
    pages     = 16'd0;
    result    = 17'd0;
    result_m1 = 17'd0;

    // start marker restarts the response
    if (st_r) begin
      pos_nxt  = 16'd0;
      len_nxt  = tot_r;
      med_nxt  = 8'd0;
      dev_nxt  = 8'd0;
      dhi_nxt  = 8'd0;
      dlen_nxt = 16'd0;
      drop_nxt = 1'b0;
    end

    if (st_r && tot_r < HDR10_BYTES) begin
      // response too short for a header
      drop_nxt  = 1'b1;
      push.n    = 3'd1;
      push.w[0] = err_w;
    end else if (!drop_nxt) begin
      pos_nxt = pos_nxt + 16'd1;
      if (pos_nxt - 16'd1 < HDR10_BYTES) begin
        // header bytes
        case (pos_nxt[2:0] - 3'd1)
          3'd2: med_nxt = b_r;
          3'd3: dev_nxt = b_r;
          3'd6: dhi_nxt = b_r;
          3'd7: begin
            dlen_nxt  = desc;
            pages     = len_nxt - HDR10_BYTES - desc;
            result    = HDR6_BYTES + {1'b0, pages};
            result_m1 = result - 17'd1;
            if (desc > len_nxt - HDR10_BYTES) begin
              drop_nxt  = 1'b1;
              push.n    = 3'd1;
              push.w[0] = err_w;
            end else if (result > {8'd0, cap_r} || result > RESULT_LIMIT) begin
              drop_nxt  = 1'b1;
              push.n    = 3'd1;
              push.w[0] = err_w;
            end else begin
              push.n    = 3'd4;
              push.w[0] = '{data: result_m1[7:0], last: 1'b0, fail: 1'b0};
              push.w[1] = '{data: med_r, last: 1'b0, fail: 1'b0};
              push.w[2] = '{data: dev_r, last: 1'b0, fail: 1'b0};
              push.w[3] = '{data: 8'd0, last: (pages == 16'd0), fail: 1'b0};
              drop_nxt  = (pages == 16'd0);
            end
          end
          default: ;
        endcase
      end else if ({1'b0, pos_r} >= {1'b0, HDR10_BYTES} + {1'b0, dlen_r}) begin
        // page bytes pass through; descriptors are skipped
        push.n    = 3'd1;
        push.w[0] = '{data: b_r, last: ({1'b0, pos_r} + 17'd1 >= {1'b0, len_r}),
                      fail: 1'b0};
        drop_nxt  = ({1'b0, pos_r} + 17'd1 >= {1'b0, len_r});
      end
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 16'd0;
      len_r  <= 16'd0;
      med_r  <= 8'd0;
      dev_r  <= 8'd0;
      dhi_r  <= 8'd0;
      dlen_r <= 16'd0;
      drop_r <= 1'b1;
    end else if (proc) begin
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      med_r  <= med_nxt;
      dev_r  <= dev_nxt;
      dhi_r  <= dhi_nxt;
      dlen_r <= dlen_nxt;
      drop_r <= drop_nxt;
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  msr_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (proc),
    .push       (push),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_word   (out_word)
  );

  assign out_tdata = out_word.data;
  assign out_tlast = out_word.last;
  assign out_tuser = out_word.fail;

endmodule
